### hw/rtl/phi4mu_pkg.sv
// Package of the phi^4 Metropolis site update: shared widths, reset values,
// register indexes and the exp(-z) table entry function.
// No dependencies.
`default_nettype none

package phi4mu_pkg;

  // default parameter values
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int EXP_DEPTH_DEF   = 256;

  // fixed point layout
  localparam int FRAC_BITS = 12;
  localparam int DS_WIDTH  = 24;
  localparam int STEP_W    = 14;
  localparam int DRAW_W    = 16;
  localparam int COEF_W    = 16;
  localparam int EXP_W     = 17;

  // step generator: dphi = floor(3r/16) - 1.5 in Q.12
  localparam logic signed [14:0] STEP_OFFSET = 15'sd6144;

  // log2(e) in Q.12 and ln(2) in Q0.32
  localparam logic [12:0] LOG2E_Q12   = 13'd5909;
  localparam logic [63:0] LN2_Q32     = 64'd2977044472;
  localparam int          SERIES_TERMS = 16;

  // largest exponent that still leaves a non-zero threshold
  localparam logic [11:0] SHIFT_MAX = 12'd16;

  // configuration register reset values
  localparam logic signed [COEF_W-1:0] MASS_RESET    = 16'sd8192;
  localparam logic signed [COEF_W-1:0] QUARTIC_RESET = 16'sd0;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_MASS    = 1'b0,
    REG_QUARTIC = 1'b1
  } cfg_reg_t;

  // exp(-z) for z in Q0.32, truncated series, rounded to Q0.16 (17 bits)
  function automatic logic [EXP_W-1:0] exp_entry(input logic [63:0] z);
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] rnd;
    term = 64'd1 << 32;
    acc  = 64'd1 << 32;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = ((term * z) >> 32) / 64'(n);
      if (n[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    rnd = (acc + 64'd32768) >> 16;
    return rnd[EXP_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/phi4_metropolis_site_update.sv
// Top level of the phi^4 Metropolis site update: step proposal, action
// change pipeline, configuration registers and stream ports.
// Depends on phi4mu_pkg and phi4mu_accept.
`default_nettype none

// Metropolis update of one site of a 2-D real phi^4 lattice. Each request
// carries the site value, its four neighbours and two Q0.16 uniform draws;
// the block proposes a step of 3r - 1.5, forms the local action change dS
// (Q12.12, saturated) and accepts when dS < 0 or accept_draw <= exp(-dS),
// exp taken from a table of 2^(-j/D). One request is taken every cycle when
// no back pressure holds the pipeline. There are nine register stages: six
// for the proposal and the multiply chain of dS (squares, the quartic
// product split in two partial products, then the coefficient products)
// and three for the exp threshold with its registered table read. Back
// pressure on the result side stalls only the stages that are full.
// Coefficients are to be written over the configuration port only while idle; the block itself does not enforce this.
module phi4_metropolis_site_update #(
  parameter int VALUE_WIDTH     = phi4mu_pkg::VALUE_WIDTH_DEF,
  parameter int EXP_TABLE_DEPTH = phi4mu_pkg::EXP_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input requests
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // site_value, right_value, left_value, up_value, down_value,
  // step_draw, accept_draw (lowest bits first)
  input  wire logic [((5*VALUE_WIDTH+32+7)/8)*8-1:0] in_tdata,
  // results
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // accepted, new_value, action_change (lowest bits first)
  output logic [((VALUE_WIDTH+25+7)/8)*8-1:0] out_tdata,
  // configuration
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [2:0]                  cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import phi4mu_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int OUT_TW = ((W+25+7)/8)*8;
  localparam int XW    = ((W > 15) ? W : 15) + 1;
  localparam int SW    = W + 2;
  localparam int PW    = W + 1;
  localparam int D2W   = STEP_W + PW;
  localparam int SQW   = 2 * W;
  localparam int LW    = STEP_W + SW;
  localparam int PRW   = D2W + SQW;
  localparam int MDW   = COEF_W + D2W;
  localparam int D4W   = PRW + 1 - 2*FRAC_BITS;
  localparam int QDW   = COEF_W + D4W;
  localparam int DSX0  = ((QDW > MDW + 1) ? QDW : MDW + 1) + 1;
  localparam int DSXW  = (DSX0 > 49) ? DSX0 : 49;
  localparam int SHW   = DSXW - 2*FRAC_BITS;
  localparam int NST   = 6;

  localparam logic signed [XW-1:0] V_MAX_X = XW'((64'sd1 <<< (W-1)) - 64'sd1);
  localparam logic signed [XW-1:0] V_MIN_X = -V_MAX_X - XW'(1);
  localparam logic signed [SHW-1:0] DS_MAX_X = SHW'((64'sd1 <<< (DS_WIDTH-1)) - 64'sd1);
  localparam logic signed [SHW-1:0] DS_MIN_X = -DS_MAX_X - SHW'(1);

  // configuration registers
  logic signed [COEF_W-1:0] mass_r;
  logic signed [COEF_W-1:0] quartic_r;
  cfg_reg_t                 cfg_idx;
  logic                     cfg_wr;

  assign cfg_idx    = cfg_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r    <= MASS_RESET;
      quartic_r <= QUARTIC_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MASS:    mass_r    <= cfg_pwdata[COEF_W-1:0];
        REG_QUARTIC: quartic_r <= cfg_pwdata[COEF_W-1:0];
        default:     ;
      endcase
    end
  end

  // register read back, sign extended
  always_comb begin
    unique case (cfg_idx)
      REG_MASS:    cfg_prdata = 32'(mass_r);
      REG_QUARTIC: cfg_prdata = 32'(quartic_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // stage valids and load enables
  logic [NST-1:0] vld_r;
  logic [NST-1:0] ld;
  logic           acc_ready;

  always_comb begin
    ld[NST-1] = !vld_r[NST-1] || acc_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
  end

  assign in_tready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (ld[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // input fields
  logic signed [W-1:0]  phi_in;
  logic signed [W-1:0]  nb_r_in;
  logic signed [W-1:0]  nb_l_in;
  logic signed [W-1:0]  nb_u_in;
  logic signed [W-1:0]  nb_d_in;
  logic [DRAW_W-1:0]    step_in;
  logic [DRAW_W-1:0]    draw_in;

  assign phi_in  = in_tdata[0 +: W];
  assign nb_r_in = in_tdata[W +: W];
  assign nb_l_in = in_tdata[2*W +: W];
  assign nb_u_in = in_tdata[3*W +: W];
  assign nb_d_in = in_tdata[4*W +: W];
  assign step_in = in_tdata[5*W +: DRAW_W];
  assign draw_in = in_tdata[5*W+DRAW_W +: DRAW_W];

  // values carried alongside the arithmetic
  logic signed [W-1:0] p_r    [NST];
  logic signed [W-1:0] phi_r  [NST];
  logic [DRAW_W-1:0]   draw_r [NST];

  // stage 1: proposed step, saturated proposal, neighbour sum
  logic [17:0]              r3_c;
  logic signed [14:0]       dphi_c;
  logic signed [XW-1:0]     sum_c;
  logic signed [W-1:0]      p_c;
  logic signed [XW-1:0]     dx_c;
  logic signed [SW-1:0]     s_c;
  logic signed [STEP_W-1:0] d1_r;
  logic signed [SW-1:0]     s1_r;

  assign r3_c   = 18'(step_in) + 18'({step_in, 1'b0});
  assign dphi_c = $signed({1'b0, r3_c[17:4]}) - STEP_OFFSET;
  assign sum_c  = XW'(phi_in) + XW'(dphi_c);

  always_comb begin
    priority if (sum_c > V_MAX_X) begin
      p_c = W'(V_MAX_X);
    end else if (sum_c < V_MIN_X) begin
      p_c = W'(V_MIN_X);
    end else begin
      p_c = W'(sum_c);
    end
  end

  assign dx_c = XW'(p_c) - XW'(phi_in);
  assign s_c  = SW'(nb_r_in) + SW'(nb_l_in) + SW'(nb_u_in) + SW'(nb_d_in);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      d1_r      <= STEP_W'(dx_c);
      s1_r      <= s_c;
      p_r[0]    <= p_c;
      phi_r[0]  <= phi_in;
      draw_r[0] <= draw_in;
    end
    for (int i = 1; i < NST; i++) begin
      if (ld[i]) begin
        p_r[i]    <= p_r[i-1];
        phi_r[i]  <= phi_r[i-1];
        draw_r[i] <= draw_r[i-1];
      end
    end
  end

  // stage 2: d*(p+phi), squares, linear term
  logic signed [PW-1:0]  pp_c;
  logic signed [D2W-1:0] d2_r;
  logic signed [SQW-1:0] psq_r;
  logic signed [SQW-1:0] phisq_r;
  logic signed [LW-1:0]  lin2_r;

  assign pp_c = PW'(p_r[0]) + PW'(phi_r[0]);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      d2_r    <= D2W'(d1_r) * D2W'(pp_c);
      psq_r   <= SQW'(p_r[0]) * SQW'(p_r[0]);
      phisq_r <= SQW'(phi_r[0]) * SQW'(phi_r[0]);
      lin2_r  <= LW'(d1_r) * LW'(s1_r);
    end
  end

  // stage 3: quartic partial products and mass product
  logic signed [PRW-1:0] pa_r;
  logic signed [PRW-1:0] pb_r;
  logic signed [MDW-1:0] md_r;
  logic signed [LW-1:0]  lin3_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      pa_r   <= PRW'(d2_r) * PRW'(psq_r);
      pb_r   <= PRW'(d2_r) * PRW'(phisq_r);
      md_r   <= MDW'(mass_r) * MDW'(d2_r);
      lin3_r <= lin2_r;
    end
  end

  // stage 4: floored quartic difference, quadratic and linear part
  logic signed [PRW:0]    prs_c;
  logic signed [D4W-1:0]  d4_r;
  logic signed [DSXW-1:0] part4_r;

  assign prs_c = (PRW+1)'(pa_r) + (PRW+1)'(pb_r);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      d4_r    <= prs_c[PRW:2*FRAC_BITS];
      part4_r <= DSXW'(md_r) - (DSXW'(lin3_r) <<< FRAC_BITS);
    end
  end

  // stage 5: quartic product
  logic signed [QDW-1:0]  qd_r;
  logic signed [DSXW-1:0] part5_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      qd_r    <= QDW'(quartic_r) * QDW'(d4_r);
      part5_r <= part4_r;
    end
  end

  // stage 6: full dS, floor to Q12.12 and saturate
  logic signed [DSXW-1:0]     ds36_c;
  logic signed [SHW-1:0]      dsh_c;
  logic signed [DS_WIDTH-1:0] ds_c;
  logic signed [DS_WIDTH-1:0] ds6_r;

  assign ds36_c = part5_r + DSXW'(qd_r);
  assign dsh_c  = ds36_c[DSXW-1:2*FRAC_BITS];

  always_comb begin
    priority if (dsh_c > DS_MAX_X) begin
      ds_c = DS_WIDTH'(DS_MAX_X);
    end else if (dsh_c < DS_MIN_X) begin
      ds_c = DS_WIDTH'(DS_MIN_X);
    end else begin
      ds_c = DS_WIDTH'(dsh_c);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      ds6_r <= ds_c;
    end
  end

  // acceptance test and result register
  logic                       res_acc;
  logic signed [W-1:0]        res_value;
  logic signed [DS_WIDTH-1:0] res_ds;

  phi4mu_accept #(
    .VALUE_WIDTH     (VALUE_WIDTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_accept (
    .clk           (clk),
    .rst_n         (rst_n),
    .ds_valid      (vld_r[NST-1]),
    .ds_ready      (acc_ready),
    .ds            (ds6_r),
    .draw          (draw_r[NST-1]),
    .site          (phi_r[NST-1]),
    .prop          (p_r[NST-1]),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .accepted      (res_acc),
    .upd_value     (res_value),
    .action_change (res_ds)
  );

  assign out_tdata = OUT_TW'({res_ds, res_value, res_acc});

  // a negative action change is always taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_ds[DS_WIDTH-1] |-> res_acc)
    else $error("negative action change rejected");

  // a rejected move leaves the site and reports no action change
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res_acc |-> (res_ds == '0))
    else $error("rejected move with non-zero action change");

  // a full pipeline behind a stalled acceptance stage refuses requests
  assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && !acc_ready |-> !in_tready)
    else $error("request taken into a full stalled pipeline");

endmodule

`default_nettype wire

### hw/rtl/phi4mu_accept.sv
// Acceptance stages of the phi^4 site update: exp(-dS) threshold from a
// power-of-two table, compare against the draw, result register.
// Depends on phi4mu_pkg.
`default_nettype none

module phi4mu_accept #(
  parameter int VALUE_WIDTH     = phi4mu_pkg::VALUE_WIDTH_DEF,
  parameter int EXP_TABLE_DEPTH = phi4mu_pkg::EXP_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  ds_valid,
  output logic                                       ds_ready,
  input  wire logic signed [phi4mu_pkg::DS_WIDTH-1:0] ds,
  input  wire logic [phi4mu_pkg::DRAW_W-1:0]         draw,
  input  wire logic signed [VALUE_WIDTH-1:0]         site,
  input  wire logic signed [VALUE_WIDTH-1:0]         prop,
  output logic                                       res_valid,
  input  wire logic                                  res_ready,
  output logic                                       accepted,
  output logic signed [VALUE_WIDTH-1:0]              upd_value,
  output logic signed [phi4mu_pkg::DS_WIDTH-1:0]     action_change
);
  import phi4mu_pkg::*;

  localparam int W    = VALUE_WIDTH;
  localparam int IDXW = $clog2(EXP_TABLE_DEPTH);
  localparam int FPW  = FRAC_BITS + IDXW;
  localparam int TPW  = DS_WIDTH + 12;

  // constant table, entry j = 2^(-j/D)
  logic [EXP_W-1:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar j = 0; j < EXP_TABLE_DEPTH; j++) begin : g_rom
    localparam logic [63:0] ZARG = (64'(j) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
    assign exp_rom[j] = exp_entry(ZARG);
  end

  // stage valids and load enables
  logic [2:0] vld_r;
  logic [2:0] ld;

  always_comb begin
    ld[2] = !vld_r[2] || res_ready;
    ld[1] = !vld_r[1] || ld[2];
    ld[0] = !vld_r[0] || ld[1];
  end

  assign ds_ready  = ld[0];
  assign res_valid = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= ds_valid;
      if (ld[1]) vld_r[1] <= vld_r[0];
      if (ld[2]) vld_r[2] <= vld_r[1];
    end
  end

  // stage a: t = dS * log2(e)
  logic [TPW-1:0]               tprod_c;
  logic [DS_WIDTH-1:0]          ta_r;
  logic                         nega_r;
  logic signed [DS_WIDTH-1:0]   dsa_r;
  logic [DRAW_W-1:0]            drawa_r;
  logic signed [W-1:0]          sitea_r;
  logic signed [W-1:0]          propa_r;

  assign tprod_c = TPW'(ds[DS_WIDTH-2:0]) * TPW'(LOG2E_Q12);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ta_r    <= tprod_c[TPW-1:FRAC_BITS];
      nega_r  <= ds[DS_WIDTH-1];
      dsa_r   <= ds;
      drawa_r <= draw;
      sitea_r <= site;
      propa_r <= prop;
    end
  end

  // stage b: table index from the fraction, registered table read
  logic [FPW-1:0]             fprod_c;
  logic [IDXW-1:0]            idx_c;
  logic [EXP_W-1:0]           romq_r;
  logic                       kbig_r;
  logic [4:0]                 ksh_r;
  logic                       negb_r;
  logic signed [DS_WIDTH-1:0] dsb_r;
  logic [DRAW_W-1:0]          drawb_r;
  logic signed [W-1:0]        siteb_r;
  logic signed [W-1:0]        propb_r;

  assign fprod_c = FPW'(ta_r[FRAC_BITS-1:0]) * FPW'(EXP_TABLE_DEPTH);
  assign idx_c   = fprod_c[FPW-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      romq_r  <= exp_rom[idx_c];
      kbig_r  <= ta_r[DS_WIDTH-1:FRAC_BITS] > SHIFT_MAX;
      ksh_r   <= ta_r[FRAC_BITS+4:FRAC_BITS];
      negb_r  <= nega_r;
      dsb_r   <= dsa_r;
      drawb_r <= drawa_r;
      siteb_r <= sitea_r;
      propb_r <= propa_r;
    end
  end

  // stage c: threshold, decision and result register
  logic [EXP_W-1:0]           thr_c;
  logic                       acc_c;
  logic                       acc_r;
  logic signed [W-1:0]        newv_r;
  logic signed [DS_WIDTH-1:0] dsout_r;

  assign thr_c = kbig_r ? '0 : (romq_r >> ksh_r);
  assign acc_c = negb_r || ({1'b0, drawb_r} <= thr_c);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      acc_r   <= acc_c;
      newv_r  <= acc_c ? propb_r : siteb_r;
      dsout_r <= acc_c ? dsb_r : '0;
    end
  end

  assign accepted      = acc_r;
  assign upd_value     = newv_r;
  assign action_change = dsout_r;

endmodule

`default_nettype wire
